>>> design/pixel_chrome_and_mask_dilate_macros.svh
// Assertion macros for the pixel chrome and mask dilation block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef PIXEL_CHROME_AND_MASK_DILATE_MACROS_SVH
`define PIXEL_CHROME_AND_MASK_DILATE_MACROS_SVH

// check cons in the same cycle as ante
`define PCMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define PCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pcmd_pkg.sv
// Shared types, constants and the chrome fold for the pixel chrome and mask dilation block.
// No dependencies.
`default_nettype none
package pcmd_pkg;

  localparam int unsigned PCMD_MAX_WIDTH  = 2048;
  localparam int unsigned PCMD_MAX_HEIGHT = 2048;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned COORD_W     = 11;
  localparam int unsigned CFG_DIM_W   = 12;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  localparam logic [PIX_W-1:0] WHITE_PIX  = 32'h00ff_ffff;
  localparam logic [7:0]       FOLD_LIMIT = 8'd128;
  localparam logic [8:0]       FOLD_BASE  = 9'd510;

  typedef enum logic [1:0] {
    MODE_CHROME = 2'd0,
    MODE_DOUBLE = 2'd1,
    MODE_TRIPLE = 2'd2,
    MODE_MASK   = 2'd3
  } pcmd_mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_TOGGLE = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } pcmd_reg_e;

  typedef struct packed {
    logic       bypass;
    pcmd_mode_e mode;
    logic       nz;
    logic       left;
    logic       first_row;
    logic       first_col;
    logic       last_row;
    logic       last_col;
  } pcmd_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [8:0] dbl;
    logic [8:0] dif;
    dbl = {c, 1'b0};
    dif = FOLD_BASE - dbl;
    return (c < FOLD_LIMIT) ? dbl[7:0] : dif[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] chrome_pixel(input logic [PIX_W-1:0] pix,
                                                    input pcmd_mode_e mode);
    logic [PIX_W-1:0] res;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    res = '0;
    for (int b = 0; b < 4; b++) begin
      c1 = fold_byte(pix[8*b +: 8]);
      c2 = fold_byte(c1);
      c3 = fold_byte(c2);
      case (mode)
        MODE_CHROME: res[8*b +: 8] = c1;
        MODE_DOUBLE: res[8*b +: 8] = c2;
        default:     res[8*b +: 8] = c3;
      endcase
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/pixel_chrome_and_mask_dilate.sv
// Top level of the pixel chrome and mask dilation block: config registers and wiring.
// Depends on pcmd_pkg, pcmd_ram, pcmd_front, pcmd_emit and the assertion macro header.
//
//  channel   dir  beat fields (lowest bit up)
//  s_axis    in   tdata: pixel_in[31:0]; tuser: beat
//  m_axis    out  tdata: pixel_out[31:0], out_col[42:32], out_row[53:43]; tlast: last_of_run
//  cfg       in   index 0 mode, 1 beat toggle enable, 2 frame_width, 3 frame_height
//
// One pixel is taken every cycle unless stalled; results pass the item and output registers.
// In mask mode on the last row a pixel makes up to three results, one per cycle on the
// output register while the output accepts them, and input stalls until the last is loaded.
// Reset clears counters, frame control and config; the line store needs no clearing.
// A result waiting at the output register holds the item register; input stalls once
// that register is full.
`default_nettype none
`include "pixel_chrome_and_mask_dilate_macros.svh"
module pixel_chrome_and_mask_dilate
  import pcmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = PCMD_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = PCMD_MAX_HEIGHT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [PIX_W-1:0]      s_axis_tdata,   // pixel_in
  input  wire logic                  s_axis_tuser,   // beat
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // pixel_out, out_col, out_row, zero pad
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DIM_W-1:0]  cfg_data_i
);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  pcmd_mode_e           mode_q;
  logic                 toggle_q;
  logic [CFG_DIM_W-1:0] width_q, height_q;

  logic             retire, s1_valid, ram_en, ram_wdata, above, right;
  pcmd_ctl_t        s1_ctl;
  logic [PIX_W-1:0] s1_pix, out_pix;
  logic [CW-1:0]    s1_x, ram_addr_a, ram_addr_b;
  logic [RW-1:0]    s1_y;
  logic [COORD_W-1:0] out_col, out_row;
  logic             in_acc, held, single_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CHROME;
      toggle_q <= 1'b0;
      width_q  <= CFG_DIM_W'(RESET_WIDTH);
      height_q <= CFG_DIM_W'(RESET_HEIGHT);
    end else if (cfg_valid_i) begin
      unique case (pcmd_reg_e'(cfg_index_i))
        REG_MODE:   mode_q   <= pcmd_mode_e'(cfg_data_i[1:0]);
        REG_TOGGLE: toggle_q <= cfg_data_i[0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  pcmd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mode_i   (mode_q),
    .cfg_toggle_i (toggle_q),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pix_i     (s_axis_tdata),
    .in_beat_i    (s_axis_tuser),
    .retire_i     (retire),
    .s1_valid_o   (s1_valid),
    .s1_ctl_o     (s1_ctl),
    .s1_pix_o     (s1_pix),
    .s1_x_o       (s1_x),
    .s1_y_o       (s1_y),
    .ram_en_o     (ram_en),
    .ram_addr_a_o (ram_addr_a),
    .ram_addr_b_o (ram_addr_b),
    .ram_wdata_o  (ram_wdata)
  );

  pcmd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .we_i      (ram_en),
    .waddr_i   (ram_addr_a),
    .wdata_i   (ram_wdata),
    .re_i      (ram_en),
    .raddr_a_i (ram_addr_a),
    .raddr_b_i (ram_addr_b),
    .rdata_a_o (above),
    .rdata_b_o (right)
  );

  pcmd_emit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ctl_i    (s1_ctl),
    .s1_pix_i    (s1_pix),
    .s1_x_i      (s1_x),
    .s1_y_i      (s1_y),
    .above_i     (above),
    .right_i     (right),
    .retire_o    (retire),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_DATA_W - PIX_W - 2 * COORD_W)'(0), out_row, out_col, out_pix};

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign held        = s1_valid && !retire;
  assign single_done = s1_valid && retire && (s1_ctl.bypass || s1_ctl.mode != MODE_MASK);

  `PCMD_ASSERT_NEXT(a_accept_fills, in_acc, s1_valid, "accepted beat lost")
  `PCMD_ASSERT_NEXT(a_held_item, held, s1_valid && $stable(s1_x) && $stable(s1_y), "held beat moved")
  `PCMD_ASSERT_NEXT(a_single_result, single_done, m_axis_tvalid && m_axis_tlast, "result lost")
endmodule
`default_nettype wire

>>> design/pcmd_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pcmd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_a_i,
  input  wire logic [AW-1:0]        raddr_b_i,
  output logic      [WIDTH-1:0]     rdata_a_o,
  output logic      [WIDTH-1:0]     rdata_b_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end
endmodule
`default_nettype wire

>>> design/pcmd_front.sv
// Input side: raster counters, frame start control, line store access and item register.
// Depends on pcmd_pkg.
`default_nettype none
module pcmd_front
  import pcmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = PCMD_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = PCMD_MAX_HEIGHT,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pcmd_mode_e           cfg_mode_i,
  input  wire logic                 cfg_toggle_i,
  input  wire logic [CFG_DIM_W-1:0] cfg_width_i,
  input  wire logic [CFG_DIM_W-1:0] cfg_height_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PIX_W-1:0]     in_pix_i,
  input  wire logic                 in_beat_i,
  input  wire logic                 retire_i,
  output logic                      s1_valid_o,
  output pcmd_ctl_t                 s1_ctl_o,
  output logic      [PIX_W-1:0]     s1_pix_o,
  output logic      [CW-1:0]        s1_x_o,
  output logic      [RW-1:0]        s1_y_o,
  output logic                      ram_en_o,
  output logic      [CW-1:0]        ram_addr_a_o,
  output logic      [CW-1:0]        ram_addr_b_o,
  output logic                      ram_wdata_o
);
  localparam int unsigned DWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DWH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EWW = (DWW > CFG_DIM_W) ? DWW : CFG_DIM_W;
  localparam int unsigned EWH = (DWH > CFG_DIM_W) ? DWH : CFG_DIM_W;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           left_q;
  logic           toggle_q, toggle_d;
  logic           bypass_q, bypass_d;
  pcmd_mode_e     fmode_q, fmode_d;
  logic           s1_valid_q;
  pcmd_ctl_t      s1_ctl_q, ctl_d;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]  s1_x_q;
  logic [RW-1:0]  s1_y_q;

  logic [EWW-1:0] fw_ext, w_eff, col_ext, x_e;
  logic [EWH-1:0] fh_ext, h_eff, row_ext, y_e;
  logic [CW-1:0]  x;
  logic [RW-1:0]  y;
  logic           first, last_col, last_row, nz, accept;

  always_comb begin
    fw_ext  = EWW'(cfg_width_i);
    fh_ext  = EWH'(cfg_height_i);
    w_eff   = (fw_ext == '0) ? EWW'(1) : (fw_ext > EWW'(MAX_WIDTH)) ? EWW'(MAX_WIDTH) : fw_ext;
    h_eff   = (fh_ext == '0) ? EWH'(1) :
              (fh_ext > EWH'(MAX_HEIGHT)) ? EWH'(MAX_HEIGHT) : fh_ext;
    col_ext = EWW'(col_q);
    row_ext = EWH'(row_q);
    x_e     = (col_ext >= w_eff) ? w_eff - EWW'(1) : col_ext;
    y_e     = (row_ext >= h_eff) ? h_eff - EWH'(1) : row_ext;
    x       = x_e[CW-1:0];
    y       = y_e[RW-1:0];
    last_col = (x_e == w_eff - EWW'(1));
    last_row = (y_e == h_eff - EWH'(1));
    first    = (x == '0) && (y == '0);
    nz       = |in_pix_i[23:0];

    toggle_d = toggle_q;
    bypass_d = bypass_q;
    fmode_d  = fmode_q;
    if (first) begin
      fmode_d = cfg_mode_i;
      if (cfg_toggle_i) begin
        toggle_d = toggle_q ^ in_beat_i;
        bypass_d = !toggle_d;
      end else begin
        bypass_d = 1'b0;
      end
    end

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : y + RW'(1);
    end else begin
      col_d = x + CW'(1);
      row_d = y;
    end

    ctl_d.bypass    = bypass_d;
    ctl_d.mode      = fmode_d;
    ctl_d.nz        = nz;
    ctl_d.left      = left_q;
    ctl_d.first_row = (y == '0);
    ctl_d.first_col = (x == '0);
    ctl_d.last_row  = last_row;
    ctl_d.last_col  = last_col;
  end

  assign in_ready_o   = !s1_valid_q || retire_i;
  assign accept       = in_valid_i && in_ready_o;
  assign ram_en_o     = accept;
  assign ram_addr_a_o = x;
  assign ram_addr_b_o = x + CW'(1);
  assign ram_wdata_o  = nz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= 1'b0;
      toggle_q   <= 1'b0;
      bypass_q   <= 1'b0;
      fmode_q    <= MODE_CHROME;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q    <= col_d;
        row_q    <= row_d;
        left_q   <= nz;
        toggle_q <= toggle_d;
        bypass_q <= bypass_d;
        fmode_q  <= fmode_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q <= ctl_d;
      s1_pix_q <= in_pix_i;
      s1_x_q   <= x;
      s1_y_q   <= y;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = s1_ctl_q;
  assign s1_pix_o   = s1_pix_q;
  assign s1_x_o     = s1_x_q;
  assign s1_y_o     = s1_y_q;
endmodule
`default_nettype wire

>>> design/pcmd_emit.sv
// Result side: forms up to three results per item and drives the output register.
// Depends on pcmd_pkg.
`default_nettype none
module pcmd_emit
  import pcmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = PCMD_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = PCMD_MAX_HEIGHT,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s1_valid_i,
  input  wire pcmd_ctl_t            s1_ctl_i,
  input  wire logic [PIX_W-1:0]     s1_pix_i,
  input  wire logic [CW-1:0]        s1_x_i,
  input  wire logic [RW-1:0]        s1_y_i,
  input  wire logic                 above_i,
  input  wire logic                 right_i,
  output logic                      retire_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [PIX_W-1:0]     out_pix_o,
  output logic      [COORD_W-1:0]   out_col_o,
  output logic      [COORD_W-1:0]   out_row_o,
  output logic                      out_last_o
);
  logic [2:0] done_q, done_d, en, pend, sel, rest;
  logic       out_valid_q;
  logic [PIX_W-1:0]   out_pix_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic       out_last_q;
  logic       out_load, emit, is_mask;
  logic [PIX_W-1:0] val_pix;
  logic [CW-1:0]    val_x;
  logic [RW-1:0]    val_y;
  logic             v_up, v_left;

  always_comb begin
    is_mask = !s1_ctl_i.bypass && (s1_ctl_i.mode == MODE_MASK);
    if (is_mask) begin
      en[0] = !s1_ctl_i.first_row;
      en[1] = s1_ctl_i.last_row && !s1_ctl_i.first_col;
      en[2] = s1_ctl_i.last_row && s1_ctl_i.last_col;
    end else begin
      en = 3'b001;
    end
    pend     = s1_valid_i ? (en & ~done_q) : 3'b000;
    sel      = pend & (~pend + 3'd1);
    rest     = pend & ~sel;
    out_load = !out_valid_q || out_ready_i;
    emit     = out_load && (pend != 3'b000);
    retire_o = s1_valid_i && ((pend == 3'b000) || (emit && (rest == 3'b000)));
    done_d   = retire_o ? 3'b000 : (emit ? (done_q | sel) : done_q);

    v_up   = above_i || (right_i && !s1_ctl_i.last_col) || s1_ctl_i.nz;
    v_left = s1_ctl_i.left || s1_ctl_i.nz;
    val_x  = s1_x_i;
    val_y  = s1_y_i;
    if (!is_mask) begin
      val_pix = s1_ctl_i.bypass ? s1_pix_i : chrome_pixel(s1_pix_i, s1_ctl_i.mode);
    end else if (sel[0]) begin
      val_pix = v_up ? WHITE_PIX : '0;
      val_y   = s1_y_i - RW'(1);
    end else if (sel[1]) begin
      val_pix = v_left ? WHITE_PIX : '0;
      val_x   = s1_x_i - CW'(1);
    end else begin
      val_pix = s1_ctl_i.nz ? WHITE_PIX : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (out_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pix_q  <= val_pix;
      out_col_q  <= COORD_W'(val_x);
      out_row_q  <= COORD_W'(val_y);
      out_last_q <= (rest == 3'b000);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_last_o  = out_last_q;
endmodule
`default_nettype wire
